// File: rtl/glq_pkg.sv
// Shared types and constants of the glyph quad layout engine.
// Depends on nothing; the RTL files that use it refer to it by scoped names.
package glq_pkg;

  // Glyph table geometry: one entry for every character code.
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned GLYPH_COUNT = 2 ** CODE_W;

  // Input function codes.
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_ORIGIN = 2'd1;
  localparam logic [1:0] FUNC_PLACE  = 2'd2;

  // Corner codes, in emission order.
  localparam logic [1:0] CORNER_UL = 2'd0;
  localparam logic [1:0] CORNER_UR = 2'd1;
  localparam logic [1:0] CORNER_LR = 2'd2;
  localparam logic [1:0] CORNER_LL = 2'd3;

  // Configuration registers.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ATLAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ATLAS_HEIGHT = 1'b1;
  localparam int unsigned INV_W      = 25;
  localparam logic [INV_W-1:0] INV_RESET = 25'd65536;

  // Texture coordinate arithmetic: 17-bit coordinate times 1.24 reciprocal.
  localparam int unsigned COORD_W   = 17;
  localparam int unsigned PROD_W    = COORD_W + INV_W;
  localparam int unsigned TEX_SHIFT = 8;
  localparam int unsigned TEX_W     = 17;
  localparam logic [TEX_W-1:0] TEX_MAX = '1;

  // Queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);

  // One glyph table entry.
  typedef struct packed {
    logic signed [15:0] advance;
    logic signed [15:0] off_y;
    logic signed [15:0] off_x;
    logic [15:0]        box_h;
    logic [15:0]        box_w;
    logic [15:0]        atlas_y;
    logic [15:0]        atlas_x;
  } glq_glyph_t;

  // One placed character, ready for corner generation.
  typedef struct packed {
    logic [31:0] left;
    logic [31:0] top;
    logic [31:0] pen_after;
    logic [15:0] atlas_x;
    logic [15:0] atlas_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
  } glq_entry_t;

endpackage

// File: rtl/glq_if.sv
// Valid/ready channel interfaces of the glyph quad layout engine.
// Standalone; the payload widths follow the block's item fields.
interface glq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [7:0]         char_code;
  logic [15:0]        atlas_x;
  logic [15:0]        atlas_y;
  logic [15:0]        box_width;
  logic [15:0]        box_height;
  logic signed [15:0] draw_offset_x;
  logic signed [15:0] draw_offset_y;
  logic signed [15:0] advance;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;

  modport source (
    output valid, func, char_code, atlas_x, atlas_y, box_width, box_height,
           draw_offset_x, draw_offset_y, advance, origin_x, origin_y,
    input  ready
  );
  modport sink (
    input  valid, func, char_code, atlas_x, atlas_y, box_width, box_height,
           draw_offset_x, draw_offset_y, advance, origin_x, origin_y,
    output ready
  );
endinterface

interface glq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         corner;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic signed [31:0] pen_after;
  logic               last_corner;

  modport source (
    output valid, corner, screen_x, screen_y, tex_u, tex_v, pen_after, last_corner,
    input  ready
  );
  modport sink (
    input  valid, corner, screen_x, screen_y, tex_u, tex_v, pen_after, last_corner,
    output ready
  );
endinterface

// File: rtl/glq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the glyph table.
module glq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/glq_front.sv
// Front of the layout engine: takes input words, keeps the glyph table and the pen.
// Depends on glq_pkg, glq_if and glq_ram.
module glq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  glq_in_if.sink              in_i,
  output logic                push_o,
  output glq_pkg::glq_entry_t push_data_o,
  input  logic                full_i
);

  logic                          accept;
  logic                          is_place;
  logic                          is_origin;
  logic                          fire;
  glq_pkg::glq_glyph_t           wr_glyph;
  glq_pkg::glq_glyph_t           rd_glyph;
  glq_pkg::glq_glyph_t           glyph;
  logic [glq_pkg::GLYPH_COUNT-1:0] written_q;
  logic                          s1_valid_q;
  logic                          s1_place_q;
  logic                          s1_hit_q;
  logic [31:0]                   s1_org_x_q;
  logic [31:0]                   s1_org_y_q;
  logic [31:0]                   pen_x_q, pen_x_d;
  logic [31:0]                   pen_y_q, pen_y_d;
  logic [31:0]                   off_x, off_y, adv;
  logic [31:0]                   left, top, after;

  assign accept    = in_i.valid && in_i.ready;
  assign is_place  = (in_i.func == glq_pkg::FUNC_PLACE);
  assign is_origin = (in_i.func == glq_pkg::FUNC_ORIGIN);

  assign wr_glyph.atlas_x = in_i.atlas_x;
  assign wr_glyph.atlas_y = in_i.atlas_y;
  assign wr_glyph.box_w   = in_i.box_width;
  assign wr_glyph.box_h   = in_i.box_height;
  assign wr_glyph.off_x   = in_i.draw_offset_x;
  assign wr_glyph.off_y   = in_i.draw_offset_y;
  assign wr_glyph.advance = in_i.advance;

  glq_ram #(
    .WIDTH ($bits(glq_pkg::glq_glyph_t)),
    .DEPTH (glq_pkg::GLYPH_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (accept && (in_i.func == glq_pkg::FUNC_WRITE)),
    .waddr_i (in_i.char_code),
    .wdata_i (wr_glyph),
    .re_i    (accept && is_place),
    .raddr_i (in_i.char_code),
    .rdata_o (rd_glyph)
  );

  // An entry never written since reset reads as an all-zero glyph.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (accept && (in_i.func == glq_pkg::FUNC_WRITE)) begin
      written_q[in_i.char_code] <= 1'b1;
    end
  end

  assign glyph = s1_hit_q ? rd_glyph : '0;

  // The held item retires when it is an origin or when the queue has room.
  assign fire       = s1_valid_q && (!s1_place_q || !full_i);
  assign in_i.ready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_place_q <= 1'b0;
      s1_hit_q   <= 1'b0;
    end else if (accept && (is_place || is_origin)) begin
      s1_valid_q <= 1'b1;
      s1_place_q <= is_place;
      s1_hit_q   <= written_q[in_i.char_code];
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_origin) begin
      s1_org_x_q <= in_i.origin_x;
      s1_org_y_q <= in_i.origin_y;
    end
  end

  assign off_x = {{16{glyph.off_x[15]}}, glyph.off_x};
  assign off_y = {{16{glyph.off_y[15]}}, glyph.off_y};
  assign adv   = {{16{glyph.advance[15]}}, glyph.advance};
  assign left  = pen_x_q + off_x;
  assign top   = pen_y_q + off_y;
  assign after = pen_x_q + adv;

  always_comb begin
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (fire) begin
      if (s1_place_q) begin
        pen_x_d = after;
      end else begin
        pen_x_d = s1_org_x_q;
        pen_y_d = s1_org_y_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
    end
  end

  assign push_o                = fire && s1_place_q;
  assign push_data_o.left      = left;
  assign push_data_o.top       = top;
  assign push_data_o.pen_after = after;
  assign push_data_o.atlas_x   = glyph.atlas_x;
  assign push_data_o.atlas_y   = glyph.atlas_y;
  assign push_data_o.box_w     = glyph.box_w;
  assign push_data_o.box_h     = glyph.box_h;

endmodule

// File: rtl/glq_fifo.sv
// Short queue of placed characters between the front and the back.
// Depends on glq_pkg.
module glq_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  glq_pkg::glq_entry_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output glq_pkg::glq_entry_t head_o,
  output logic                head_valid_o
);

  glq_pkg::glq_entry_t        mem_q [glq_pkg::FIFO_DEPTH];
  logic [glq_pkg::FIFO_PW-1:0] wr_ptr_q;
  logic [glq_pkg::FIFO_PW-1:0] rd_ptr_q;
  logic [glq_pkg::FIFO_PW:0]   count_q;

  assign full_o       = (count_q == (glq_pkg::FIFO_PW + 1)'(glq_pkg::FIFO_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/glq_back.sv
// Back of the layout engine: walks the four corners of each queued character.
// Depends on glq_pkg and glq_if.
module glq_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  glq_pkg::glq_entry_t       head_i,
  input  logic                      head_valid_i,
  output logic                      pop_o,
  input  logic [glq_pkg::INV_W-1:0] inv_w_i,
  input  logic [glq_pkg::INV_W-1:0] inv_h_i,
  glq_out_if.source                 out_o
);

  logic                       load;
  logic                       right;
  logic                       lower;
  logic [1:0]                 cnt_q;
  logic                       out_valid_q;
  logic [1:0]                 corner_q;
  logic [31:0]                sx_q, sy_q, after_q;
  logic [glq_pkg::PROD_W-1:0] pu_q, pv_q;
  logic [glq_pkg::COORD_W-1:0] cu, cv;

  assign load  = head_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o = load && (cnt_q == glq_pkg::CORNER_LL);

  assign right = (cnt_q == glq_pkg::CORNER_UR) || (cnt_q == glq_pkg::CORNER_LR);
  assign lower = (cnt_q == glq_pkg::CORNER_LR) || (cnt_q == glq_pkg::CORNER_LL);

  assign cu = glq_pkg::COORD_W'(head_i.atlas_x) +
              (right ? glq_pkg::COORD_W'(head_i.box_w) : '0);
  assign cv = glq_pkg::COORD_W'(head_i.atlas_y) +
              (lower ? glq_pkg::COORD_W'(head_i.box_h) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= glq_pkg::CORNER_UL;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cnt_q       <= cnt_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      corner_q <= cnt_q;
      sx_q     <= head_i.left + (right ? {16'd0, head_i.box_w} : 32'd0);
      sy_q     <= head_i.top + (lower ? {16'd0, head_i.box_h} : 32'd0);
      after_q  <= head_i.pen_after;
      pu_q     <= glq_pkg::PROD_W'(cu) * glq_pkg::PROD_W'(inv_w_i);
      pv_q     <= glq_pkg::PROD_W'(cv) * glq_pkg::PROD_W'(inv_h_i);
    end
  end

  // Coordinates past the 1.16 range saturate.
  assign out_o.tex_u = (|pu_q[glq_pkg::PROD_W-1:glq_pkg::TEX_W+glq_pkg::TEX_SHIFT]) ?
                       glq_pkg::TEX_MAX :
                       pu_q[glq_pkg::TEX_W+glq_pkg::TEX_SHIFT-1:glq_pkg::TEX_SHIFT];
  assign out_o.tex_v = (|pv_q[glq_pkg::PROD_W-1:glq_pkg::TEX_W+glq_pkg::TEX_SHIFT]) ?
                       glq_pkg::TEX_MAX :
                       pv_q[glq_pkg::TEX_W+glq_pkg::TEX_SHIFT-1:glq_pkg::TEX_SHIFT];

  assign out_o.valid       = out_valid_q;
  assign out_o.corner      = corner_q;
  assign out_o.screen_x    = sx_q;
  assign out_o.screen_y    = sy_q;
  assign out_o.pen_after   = after_q;
  assign out_o.last_corner = (corner_q == glq_pkg::CORNER_LL);

endmodule

// File: rtl/glyph_quad_layout_top.sv
// Top level of the glyph quad layout engine: configuration registers and wiring.
// Depends on glq_pkg, glq_if, glq_front, glq_fifo and glq_back.
//
//   Channel   Direction  Word                          Handshake
//   in_i      in         func, code, box, offsets      valid/ready
//   out_o     out        one quad corner               valid/ready
//   cfg_*     in         register index and value      write enable only
//
// A write or origin word is taken every cycle unless a held character waits on
// a full queue. A character word is taken every cycle as long as the two-entry
// queue has room, but the corner sequencer in the back emits one corner per
// cycle while the output is ready and pops a character with its last corner.
// A character's first corner goes from the held stage, which resolves the glyph
// and the pen and writes the queue, through the queue into the corner register.
// Reset clears the pen, the glyph valid bits and the queue at once; there is no
// clearing pass. A stalled output only holds the back; the front keeps taking
// words until the queue fills.
module glyph_quad_layout_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [glq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [glq_pkg::INV_W-1:0]     cfg_wdata_i,
  glq_in_if.sink                        in_i,
  glq_out_if.source                     out_o
);

  // Reciprocals of the atlas size in 1.24 fixed point.
  logic [glq_pkg::INV_W-1:0] inv_w_q;
  logic [glq_pkg::INV_W-1:0] inv_h_q;

  glq_pkg::glq_entry_t push_data;
  glq_pkg::glq_entry_t head;
  logic                push;
  logic                full;
  logic                pop;
  logic                head_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_w_q <= glq_pkg::INV_RESET;
      inv_h_q <= glq_pkg::INV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        glq_pkg::CFG_INV_ATLAS_WIDTH:  inv_w_q <= cfg_wdata_i;
        glq_pkg::CFG_INV_ATLAS_HEIGHT: inv_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The front resolves the glyph and the pen for each character.
  glq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // The queue lets the front run ahead while the back waits on the output.
  glq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  // The back turns one queued character into its four corners.
  glq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .inv_w_i      (inv_w_q),
    .inv_h_i      (inv_h_q),
    .out_o        (out_o)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for glyph_quad_layout_top: directed table, then random phases.
// Depends on glq_pkg, glq_if and the RTL of the glyph quad layout engine.
module tb;
  import glq_pkg::*;

  // Function code 3 is not decoded by the block; the word is taken and dropped.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Cycles the block may still be busy after the last corner has been seen.
  localparam int unsigned SETTLE_CYCLES = 8;

  // One input word as the testbench sees it. Signed fields are kept as raw bits.
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  code;
    logic [15:0] atlas_x;
    logic [15:0] atlas_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [15:0] off_x;
    logic [15:0] off_y;
    logic [15:0] advance;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
  } glyph_word_t;

  // One corner word of a placed character.
  typedef struct packed {
    logic [1:0]  corner;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [31:0] pen_after;
    logic        last_corner;
  } quad_corner_t;

  // A row of the directed table. When has_ul is set, the upper left corner is
  // typed in by hand and replaces the predicted one.
  typedef struct packed {
    glyph_word_t  w;
    logic         has_ul;
    quad_corner_t ul;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [INV_W-1:0]     cfg_wdata_i;

  glq_in_if  in_if ();
  glq_out_if out_if ();

  glyph_quad_layout_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the block's state, kept in step with every accepted word.
  glq_glyph_t       glyph_mem [GLYPH_COUNT];
  logic [31:0]      pen_x;
  logic [31:0]      pen_y;
  logic [INV_W-1:0] inv_w;
  logic [INV_W-1:0] inv_h;

  // Corners still owed by the block, oldest first.
  quad_corner_t corner_q [$];

  // When calm is set, neither side inserts idle cycles.
  logic        calm = 1'b0;
  logic [7:0]  code_pool [8];
  int unsigned error_cnt = 0;
  int unsigned words_sent = 0;
  int unsigned chars_placed = 0;
  int unsigned corners_checked = 0;
  int unsigned settings_used = 1;
  quad_corner_t seen_corner;
  quad_corner_t due_corner;
  stim_row_t    dir_tab [$];

  task automatic report_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("%s", msg);
  endtask

  // A texture coordinate is the texel coordinate times the 1.24 reciprocal,
  // scaled down to 1.16 and clamped at the largest 1.16 value.
  function automatic logic [TEX_W-1:0] tex_scale(input logic [COORD_W-1:0] coord,
                                                  input logic [INV_W-1:0] inv);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(coord) * PROD_W'(inv);
    prod = prod >> TEX_SHIFT;
    return (prod > TEX_MAX) ? TEX_MAX : prod[TEX_W-1:0];
  endfunction

  // Expands one character into its four corners and moves the pen on.
  task automatic place_char(input logic [7:0] code);
    glq_glyph_t   g;
    logic [31:0]  left;
    logic [31:0]  top;
    logic [31:0]  after;
    logic [1:0]   k;
    logic         right;
    logic         lower;
    quad_corner_t c;
    g     = glyph_mem[code];
    left  = pen_x + {{16{g.off_x[15]}}, g.off_x};
    top   = pen_y + {{16{g.off_y[15]}}, g.off_y};
    after = pen_x + {{16{g.advance[15]}}, g.advance};
    for (int i = 0; i < 4; i++) begin
      k             = 2'(i);
      right         = (k == CORNER_UR) || (k == CORNER_LR);
      lower         = (k == CORNER_LR) || (k == CORNER_LL);
      c.corner      = k;
      c.screen_x    = right ? left + {16'd0, g.box_w} : left;
      c.screen_y    = lower ? top + {16'd0, g.box_h} : top;
      c.tex_u       = tex_scale(right ? {1'b0, g.atlas_x} + {1'b0, g.box_w}
                                      : {1'b0, g.atlas_x}, inv_w);
      c.tex_v       = tex_scale(lower ? {1'b0, g.atlas_y} + {1'b0, g.box_h}
                                      : {1'b0, g.atlas_y}, inv_h);
      c.pen_after   = after;
      c.last_corner = (k == CORNER_LL);
      corner_q.push_back(c);
    end
    pen_x = after;
    chars_placed++;
  endtask

  task automatic predict_word(input glyph_word_t w);
    case (w.func)
      FUNC_WRITE: begin
        glyph_mem[w.code] = '{advance: w.advance, off_y: w.off_y, off_x: w.off_x,
                              box_h: w.box_h, box_w: w.box_w,
                              atlas_y: w.atlas_y, atlas_x: w.atlas_x};
      end
      FUNC_ORIGIN: begin
        pen_x = w.origin_x;
        pen_y = w.origin_y;
      end
      FUNC_PLACE: place_char(w.code);
      default: ;
    endcase
  endtask

  function automatic glyph_word_t mk_write(input logic [7:0] code,
                                           input logic [15:0] ax, ay, bw, bh,
                                           input logic [15:0] ox, oy, adv);
    glyph_word_t w;
    w = '0;
    w.func    = FUNC_WRITE;
    w.code    = code;
    w.atlas_x = ax;
    w.atlas_y = ay;
    w.box_w   = bw;
    w.box_h   = bh;
    w.off_x   = ox;
    w.off_y   = oy;
    w.advance = adv;
    return w;
  endfunction

  function automatic glyph_word_t mk_origin(input logic [31:0] x, input logic [31:0] y);
    glyph_word_t w;
    w = '0;
    w.func     = FUNC_ORIGIN;
    w.origin_x = x;
    w.origin_y = y;
    return w;
  endfunction

  function automatic glyph_word_t mk_place(input logic [7:0] code);
    glyph_word_t w;
    w = '0;
    w.func = FUNC_PLACE;
    w.code = code;
    return w;
  endfunction

  // An unused function code with every payload bit set to fill.
  function automatic glyph_word_t mk_unused(input logic fill);
    glyph_word_t w;
    w      = {$bits(glyph_word_t){fill}};
    w.func = FUNC_UNUSED;
    return w;
  endfunction

  function automatic quad_corner_t ul_at(input logic [31:0] x, y,
                                         input logic [16:0] u, v,
                                         input logic [31:0] pen);
    return '{corner: CORNER_UL, screen_x: x, screen_y: y, tex_u: u, tex_v: v,
             pen_after: pen, last_corner: 1'b0};
  endfunction

  // Field values lean toward the edges and toward small sizes that keep the
  // texture coordinates out of saturation.
  function automatic logic [15:0] rand16();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4, 5, 6: return 16'($urandom_range(0, 600));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'($urandom_range(0, 2000));
      default: return $urandom;
    endcase
  endfunction

  // Reciprocal of a random atlas size, rounded to nearest, as software sets it.
  function automatic logic [INV_W-1:0] recip();
    logic [31:0] sz;
    sz = $urandom_range(1, 4096);
    return INV_W'((32'd16777216 + sz / 2) / sz);
  endfunction

  // Most random words are writes and places on a small pool of codes so that
  // placed characters mostly find a glyph that was written with random content.
  function automatic glyph_word_t random_word();
    glyph_word_t w;
    int unsigned pick;
    pick       = $urandom_range(99);
    w.atlas_x  = rand16();
    w.atlas_y  = rand16();
    w.box_w    = rand16();
    w.box_h    = rand16();
    w.off_x    = rand16();
    w.off_y    = rand16();
    w.advance  = rand16();
    w.origin_x = rand32();
    w.origin_y = rand32();
    w.code     = ($urandom_range(99) < 85) ? code_pool[$urandom_range(7)] : 8'($urandom);
    if (pick < 30)      w.func = FUNC_WRITE;
    else if (pick < 40) w.func = FUNC_ORIGIN;
    else if (pick < 95) w.func = FUNC_PLACE;
    else                w.func = FUNC_UNUSED;
    return w;
  endfunction

  // Offers one word from a falling edge, optionally after random idle cycles,
  // and returns on the falling edge after it was taken. Valid stays high into
  // the next word unless that word chooses to idle first.
  task automatic send_word(input glyph_word_t w, input logic has_ul,
                           input quad_corner_t ul);
    while (!calm && $urandom_range(99) < 28) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         = 1'b1;
    in_if.func          = w.func;
    in_if.char_code     = w.code;
    in_if.atlas_x       = w.atlas_x;
    in_if.atlas_y       = w.atlas_y;
    in_if.box_width     = w.box_w;
    in_if.box_height    = w.box_h;
    in_if.draw_offset_x = w.off_x;
    in_if.draw_offset_y = w.off_y;
    in_if.advance       = w.advance;
    in_if.origin_x      = w.origin_x;
    in_if.origin_y      = w.origin_y;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_word(w);
    // The first corner cannot leave before the next edge, so the hand-typed
    // upper left corner can still replace the predicted one here.
    if (has_ul) corner_q[corner_q.size() - 4] = ul;
    words_sent++;
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every owed corner has come out, then gives
  // the block a few more cycles to finish any write or origin still in flight.
  task automatic settle();
    in_if.valid = 1'b0;
    while (corner_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [INV_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_INV_ATLAS_WIDTH) inv_w = value;
    else                            inv_h = value;
  endtask

  // The result side: ready is redrawn at every falling edge.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = calm || ($urandom_range(99) >= 28);
    end
  end

  // Every corner taken at a rising edge is checked against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_corner = '{out_if.corner, out_if.screen_x, out_if.screen_y, out_if.tex_u,
                      out_if.tex_v, out_if.pen_after, out_if.last_corner};
      if (corner_q.size() == 0) begin
        report_error($sformatf("%0t: corner %0d x %h y %h arrived with nothing owed",
                               $time, seen_corner.corner, seen_corner.screen_x,
                               seen_corner.screen_y));
      end else begin
        due_corner = corner_q.pop_front();
        corners_checked++;
        if (seen_corner !== due_corner) begin
          report_error($sformatf({
            "%0t: corner mismatch, want %0d x %h y %h u %h v %h pen %h last %0d\n",
            "%0t:                   got  %0d x %h y %h u %h v %h pen %h last %0d"},
            $time, due_corner.corner, due_corner.screen_x, due_corner.screen_y,
            due_corner.tex_u, due_corner.tex_v, due_corner.pen_after,
            due_corner.last_corner,
            $time, seen_corner.corner, seen_corner.screen_x, seen_corner.screen_y,
            seen_corner.tex_u, seen_corner.tex_v, seen_corner.pen_after,
            seen_corner.last_corner));
        end
      end
    end
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d corners still owed.", corner_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned counted;
    glyph_word_t w;

    in_if.valid = 1'b0;
    in_if.func = FUNC_WRITE;
    in_if.char_code = '0;
    in_if.atlas_x = '0;
    in_if.atlas_y = '0;
    in_if.box_width = '0;
    in_if.box_height = '0;
    in_if.draw_offset_x = '0;
    in_if.draw_offset_y = '0;
    in_if.advance = '0;
    in_if.origin_x = '0;
    in_if.origin_y = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_INV_ATLAS_WIDTH;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;

    // The shadow state starts where reset leaves the block.
    for (int i = 0; i < GLYPH_COUNT; i++) glyph_mem[i] = '0;
    pen_x = '0;
    pen_y = '0;
    inv_w = INV_RESET;
    inv_h = INV_RESET;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table, run with the reset reciprocals, so every texture
    // coordinate is simply the texel coordinate times 256 before clamping.
    // A character placed straight after reset finds an all-zero glyph.
    dir_tab.push_back('{mk_place(8'h41), 1'b1,
                        ul_at(32'h0, 32'h0, 17'd0, 17'd0, 32'h0)});
    // The unused function code must be dropped without any corner.
    dir_tab.push_back('{mk_unused(1'b1), 1'b0, '0});
    // Largest box and offsets at both signed limits; texture coordinates clamp.
    dir_tab.push_back('{mk_write(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'h8000, 16'h7FFF, 16'h7FFF), 1'b0, '0});
    dir_tab.push_back('{mk_origin(32'h7FFF_FFFF, 32'h8000_0000), 1'b0, '0});
    dir_tab.push_back('{mk_place(8'hFF), 1'b1,
                        ul_at(32'h7FFF_7FFF, 32'h8000_7FFF, TEX_MAX, TEX_MAX,
                              32'h8000_7FFE)});
    dir_tab.push_back('{mk_place(8'hFF), 1'b0, '0});
    // Empty box with the most negative advance; the pen wraps downward.
    dir_tab.push_back('{mk_write(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                 16'h0000, 16'h0000, 16'h8000), 1'b0, '0});
    dir_tab.push_back('{mk_origin(32'h8000_0000, 32'h7FFF_FFFF), 1'b0, '0});
    dir_tab.push_back('{mk_place(8'h00), 1'b1,
                        ul_at(32'h8000_0000, 32'h7FFF_FFFF, 17'd0, 17'd0,
                              32'h7FFF_8000)});
    // An ordinary glyph at the pen origin.
    dir_tab.push_back('{mk_write(8'h07, 16'd100, 16'd200, 16'd8, 16'd12,
                                 16'h0001, 16'hFFFD, 16'd9), 1'b0, '0});
    dir_tab.push_back('{mk_origin(32'h0, 32'h0), 1'b0, '0});
    dir_tab.push_back('{mk_place(8'h07), 1'b1,
                        ul_at(32'h1, 32'hFFFF_FFFD, 17'd25600, 17'd51200, 32'd9)});
    dir_tab.push_back('{mk_place(8'h07), 1'b0, '0});
    // Overwrite a glyph and place it on the very next word; the corners sit
    // right at the edge where the texture coordinate starts to clamp.
    dir_tab.push_back('{mk_write(8'h07, 16'd511, 16'd1, 16'd1, 16'd510,
                                 16'hFFFF, 16'h0001, 16'hFFFF), 1'b0, '0});
    dir_tab.push_back('{mk_place(8'h07), 1'b0, '0});
    dir_tab.push_back('{mk_origin(32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0});
    dir_tab.push_back('{mk_place(8'h07), 1'b0, '0});
    // Alternating bit patterns in every field of the glyph entry.
    dir_tab.push_back('{mk_write(8'h80, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
                                 16'h5555, 16'hAAAA, 16'h0F0F), 1'b0, '0});
    dir_tab.push_back('{mk_place(8'h80), 1'b0, '0});
    dir_tab.push_back('{mk_unused(1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_place(8'h41), 1'b0, '0});

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].has_ul, dir_tab[i].ul);
    settle();

    code_pool[0] = 8'h00;
    code_pool[1] = 8'hFF;
    for (int i = 2; i < 8; i++) code_pool[i] = 8'($urandom);

    // Random phases, each under its own pair of reciprocals. Phase 2 runs
    // with no idle cycles on either side to keep the corner path saturated.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          write_reg(CFG_INV_ATLAS_WIDTH, '0);
          write_reg(CFG_INV_ATLAS_HEIGHT, INV_W'(1 << 24));
        end
        2: begin
          write_reg(CFG_INV_ATLAS_WIDTH, INV_W'(1 << 24));
          write_reg(CFG_INV_ATLAS_HEIGHT, '0);
        end
        4: begin
          write_reg(CFG_INV_ATLAS_WIDTH, INV_W'($urandom_range(0, 1 << 24)));
          write_reg(CFG_INV_ATLAS_HEIGHT, INV_W'($urandom_range(0, 1 << 24)));
        end
        5: begin
          write_reg(CFG_INV_ATLAS_WIDTH, INV_W'(1 << 24));
          write_reg(CFG_INV_ATLAS_HEIGHT, INV_W'(1 << 24));
        end
        default: begin
          write_reg(CFG_INV_ATLAS_WIDTH, recip());
          write_reg(CFG_INV_ATLAS_HEIGHT, recip());
        end
      endcase
      settings_used++;
      calm = (phase == 2);
      counted = 0;
      while (counted < 24) begin
        w = random_word();
        send_word(w, 1'b0, '0);
        if (w.func != FUNC_UNUSED) counted++;
      end
      settle();
      calm = 1'b0;
    end

    if (corner_q.size() != 0)
      report_error($sformatf("%0d corners never arrived", corner_q.size()));

    $display("Covered %0d input words and %0d placed characters under %0d reciprocal settings.",
             words_sent, chars_placed, settings_used);
    $display("Checked %0d corners; %0d errors found.", corners_checked, error_cnt);
    if (error_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
